FILE: design/dss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

  // Default sizes of the stores
  localparam int DEF_MAX_STATES  = 8;
  localparam int DEF_MAX_INPUTS  = 8;
  localparam int DEF_MAX_OUTPUTS = 8;
  localparam int DEF_COEF_DEPTH  = 256;

  // Output vectors never carry more than this many elements
  localparam int RESULT_LIMIT = 8;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int FRAC_W    = 16;
  localparam int CNT_W     = 5;   // counts up to 31
  localparam int ADDR_W    = 11;  // coefficient address incl. out-of-range values
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;

  typedef enum logic [1:0] {
    OP_COEF   = 2'd0,
    OP_STATE  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_STATES  = 2'd0,
    REG_NUM_INPUTS  = 2'd1,
    REG_NUM_OUTPUTS = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW_START,
    ST_ROW_X,
    ST_ROW_U,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // One multiply-accumulate term handed to the MAC
  typedef struct packed {
    logic valid;
    logic last;   // final term of a row
    logic zero;   // coefficient address out of range
  } term_t;

endpackage

`default_nettype wire

FILE: design/dss_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_mac (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dss_pkg::term_t                   term,
  input  wire logic signed [dss_pkg::DATA_W-1:0] coef,
  input  wire logic signed [dss_pkg::DATA_W-1:0] opnd,
  output logic                                  res_valid,
  output logic signed [dss_pkg::DATA_W-1:0]      res_value
);

  localparam logic signed [dss_pkg::ACC_W-1:0] SAT_MAX =
    dss_pkg::ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [dss_pkg::ACC_W-1:0] SAT_MIN =
    dss_pkg::ACC_W'(64'shFFFF_FFFF_8000_0000);

  logic signed [dss_pkg::ACC_W-1:0] prod_r, prod_nxt;
  logic                             v2_r, last2_r;
  logic signed [dss_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [dss_pkg::ACC_W-1:0] sum;
  logic                             res_valid_r;
  logic signed [dss_pkg::DATA_W-1:0] res_r, res_nxt;

  always_comb begin
    prod_nxt = coef * opnd;
    if (term.zero) begin
      prod_nxt = '0;
    end
  end

  // Floor division by 2^16 is an arithmetic shift
  assign sum = acc_r + (prod_r >>> dss_pkg::FRAC_W);

  always_comb begin
    acc_nxt = acc_r;
    if (v2_r) begin
      acc_nxt = last2_r ? '0 : sum;
    end
    if (sum > SAT_MAX) begin
      res_nxt = SAT_MAX[dss_pkg::DATA_W-1:0];
    end else if (sum < SAT_MIN) begin
      res_nxt = SAT_MIN[dss_pkg::DATA_W-1:0];
    end else begin
      res_nxt = sum[dss_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (v2_r && last2_r) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      last2_r     <= 1'b0;
      acc_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      v2_r        <= term.valid;
      last2_r     <= term.last;
      acc_r       <= acc_nxt;
      res_valid_r <= v2_r && last2_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res_value = res_r;

endmodule

`default_nettype wire

FILE: design/discrete_state_space_system_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Coefficient, state and non-final sample items are taken while the core is idle.
// A final sample holds the input until all rows are done: one shared MAC term per cycle
// within a row, a start state and a drain per row, and an output row waits at its start
// until the output register is free, which out_stall can hold off.
// Reset: synchronous, active low; clears state vector and control; sets 0 states, 1 input, 1 output.
module discrete_state_space_system_core #(
  parameter int MAX_STATES  = dss_pkg::DEF_MAX_STATES,
  parameter int MAX_INPUTS  = dss_pkg::DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = dss_pkg::DEF_MAX_OUTPUTS,
  parameter int COEF_DEPTH  = dss_pkg::DEF_COEF_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dss_pkg::CFG_W-1:0]           cfg_value,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_opcode,
  input  wire logic [7:0]                          in_index,
  input  wire logic signed [dss_pkg::DATA_W-1:0]   in_value,
  input  wire logic                                in_last_element,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [2:0]                               out_index,
  output logic signed [dss_pkg::DATA_W-1:0]        out_value,
  output logic                                     out_last
);

  localparam int CW   = dss_pkg::CNT_W;
  localparam int AW   = dss_pkg::ADDR_W;
  localparam int DW   = dss_pkg::DATA_W;
  localparam int SIW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int IIW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int CAW  = $clog2(COEF_DEPTH);
  localparam int OUT_CAP = (MAX_OUTPUTS < dss_pkg::RESULT_LIMIT) ?
                           MAX_OUTPUTS : dss_pkg::RESULT_LIMIT;

  // Configuration registers
  logic [dss_pkg::CFG_W-1:0] num_states_r, num_inputs_r, num_outputs_r;

  // Stores
  logic signed [DW-1:0] coef_mem [COEF_DEPTH];
  logic signed [DW-1:0] state_vec_r [MAX_STATES];
  logic signed [DW-1:0] input_buf_r [MAX_INPUTS];
  logic signed [DW-1:0] next_state_r [MAX_STATES];

  // Sequencer
  dss_pkg::state_t state_r, state_nxt;
  logic          phase_st_r, phase_st_nxt;   // 0: output rows, 1: state rows
  logic [CW-1:0] ns_r, ns_nxt, ni_r, ni_nxt, no_r, no_nxt;
  logic [AW-1:0] lb_r, lb_nxt, lc_r, lc_nxt, ld_r, ld_nxt;
  logic [CW-1:0] row_r, row_nxt, j_r, j_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  logic          in_acc;
  dss_pkg::op_t  op;
  logic [CW-1:0] ns_c, ni_c, no_c, stride;
  logic [AW-1:0] xbase, ubase;
  logic          issue, issue_last;
  logic signed [DW-1:0] opnd;
  logic          commit;
  logic          st_wr;

  // Stage between sequencer and MAC
  dss_pkg::term_t       term_q;
  logic signed [DW-1:0] coef_q, opnd_q;

  logic                 res_valid;
  logic signed [DW-1:0] res_value;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_index_r;
  logic signed [DW-1:0] out_value_r;
  logic          out_last_r;
  logic          out_load;

  assign in_stall = (state_r != dss_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign op       = dss_pkg::op_t'(in_opcode);

  // Effective sizes
  always_comb begin
    ns_c = (num_states_r > MAX_STATES) ? CW'(MAX_STATES) : CW'(num_states_r);
    if (num_inputs_r == '0) begin
      ni_c = CW'(1);
    end else if (num_inputs_r > MAX_INPUTS) begin
      ni_c = CW'(MAX_INPUTS);
    end else begin
      ni_c = CW'(num_inputs_r);
    end
    if (num_outputs_r == '0) begin
      no_c = CW'(1);
    end else if (num_outputs_r > OUT_CAP) begin
      no_c = CW'(OUT_CAP);
    end else begin
      no_c = CW'(num_outputs_r);
    end
  end

  assign xbase  = phase_st_r ? '0 : lc_r;
  assign ubase  = phase_st_r ? lb_r : ld_r;
  assign stride = phase_st_r ? ns_r : no_r;

  always_comb begin
    opnd = input_buf_r[j_r[IIW-1:0]];
    if (state_r == dss_pkg::ST_ROW_X) begin
      opnd = state_vec_r[j_r[SIW-1:0]];
    end
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt    = state_r;
    phase_st_nxt = phase_st_r;
    ns_nxt       = ns_r;
    ni_nxt       = ni_r;
    no_nxt       = no_r;
    lb_nxt       = lb_r;
    lc_nxt       = lc_r;
    ld_nxt       = ld_r;
    row_nxt      = row_r;
    j_nxt        = j_r;
    addr_nxt     = addr_r;
    issue        = 1'b0;
    issue_last   = 1'b0;
    out_load     = 1'b0;
    st_wr        = 1'b0;
    commit       = 1'b0;
    unique case (state_r)
      dss_pkg::ST_IDLE: begin
        if (in_acc && op == dss_pkg::OP_SAMPLE && in_last_element) begin
          state_nxt = dss_pkg::ST_SETUP;
        end
      end
      dss_pkg::ST_SETUP: begin
        ns_nxt       = ns_c;
        ni_nxt       = ni_c;
        no_nxt       = no_c;
        lb_nxt       = AW'(ns_c) * AW'(ns_c);
        lc_nxt       = AW'(ns_c) * AW'(ns_c) + AW'(ns_c) * AW'(ni_c);
        ld_nxt       = AW'(ns_c) * AW'(ns_c) + AW'(ns_c) * AW'(ni_c)
                       + AW'(ns_c) * AW'(no_c);
        phase_st_nxt = 1'b0;
        row_nxt      = '0;
        state_nxt    = dss_pkg::ST_ROW_START;
      end
      dss_pkg::ST_ROW_START: begin
        // an output row starts only when the output register is free
        if (phase_st_r || !out_valid_r) begin
          j_nxt = '0;
          if (ns_r != '0) begin
            addr_nxt  = xbase + AW'(row_r);
            state_nxt = dss_pkg::ST_ROW_X;
          end else begin
            addr_nxt  = ubase + AW'(row_r);
            state_nxt = dss_pkg::ST_ROW_U;
          end
        end
      end
      dss_pkg::ST_ROW_X: begin
        issue = 1'b1;
        if (CW'(j_r + CW'(1)) == ns_r) begin
          j_nxt     = '0;
          addr_nxt  = ubase + AW'(row_r);
          state_nxt = dss_pkg::ST_ROW_U;
        end else begin
          j_nxt    = CW'(j_r + CW'(1));
          addr_nxt = addr_r + AW'(stride);
        end
      end
      dss_pkg::ST_ROW_U: begin
        issue = 1'b1;
        if (CW'(j_r + CW'(1)) == ni_r) begin
          issue_last = 1'b1;
          state_nxt  = dss_pkg::ST_DRAIN;
        end else begin
          j_nxt    = CW'(j_r + CW'(1));
          addr_nxt = addr_r + AW'(stride);
        end
      end
      dss_pkg::ST_DRAIN: begin
        if (res_valid) begin
          row_nxt   = CW'(row_r + CW'(1));
          state_nxt = dss_pkg::ST_ROW_START;
          if (!phase_st_r) begin
            out_load = 1'b1;
            if (CW'(row_r + CW'(1)) == no_r) begin
              row_nxt      = '0;
              phase_st_nxt = 1'b1;
              if (ns_r == '0) begin
                state_nxt = dss_pkg::ST_IDLE;
              end
            end
          end else begin
            st_wr = 1'b1;
            if (CW'(row_r + CW'(1)) == ns_r) begin
              state_nxt = dss_pkg::ST_COMMIT;
            end
          end
        end
      end
      dss_pkg::ST_COMMIT: begin
        commit    = 1'b1;
        state_nxt = dss_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dss_pkg::ST_IDLE;
      phase_st_r <= 1'b0;
      row_r      <= '0;
      j_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_st_r <= phase_st_nxt;
      row_r      <= row_nxt;
      j_r        <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ns_r   <= ns_nxt;
    ni_r   <= ni_nxt;
    no_r   <= no_nxt;
    lb_r   <= lb_nxt;
    lc_r   <= lc_nxt;
    ld_r   <= ld_nxt;
    addr_r <= addr_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r  <= '0;
      num_inputs_r  <= dss_pkg::CFG_W'(1);
      num_outputs_r <= dss_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      unique case (dss_pkg::cfg_reg_t'(cfg_index))
        dss_pkg::REG_NUM_STATES:  num_states_r  <= cfg_value;
        dss_pkg::REG_NUM_INPUTS:  num_inputs_r  <= cfg_value;
        dss_pkg::REG_NUM_OUTPUTS: num_outputs_r <= cfg_value;
        default: ;
      endcase
    end
  end

  // Coefficient memory: write from the input channel, registered read for the MAC
  always_ff @(posedge clk) begin
    if (in_acc && op == dss_pkg::OP_COEF && AW'(in_index) < AW'(COEF_DEPTH)) begin
      coef_mem[CAW'(in_index)] <= in_value;
    end
    coef_q <= coef_mem[CAW'(addr_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_q <= '0;
    end else begin
      term_q.valid <= issue;
      term_q.last  <= issue_last;
      term_q.zero  <= !(addr_r < AW'(COEF_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    opnd_q <= opnd;
  end

  // State vector: preload from the input channel, update from the next-state buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_STATES; k++) begin
        state_vec_r[k] <= '0;
      end
    end else if (commit) begin
      for (int k = 0; k < MAX_STATES; k++) begin
        if (k < ns_r) begin
          state_vec_r[k] <= next_state_r[k];
        end
      end
    end else if (in_acc && op == dss_pkg::OP_STATE && in_index < MAX_STATES) begin
      state_vec_r[SIW'(in_index)] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (st_wr) begin
      next_state_r[row_r[SIW-1:0]] <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && op == dss_pkg::OP_SAMPLE && in_index < MAX_INPUTS) begin
      input_buf_r[IIW'(in_index)] <= in_value;
    end
  end

  dss_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .term      (term_q),
    .coef      (coef_q),
    .opnd      (opnd_q),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= row_r[2:0];
      out_value_r <= res_value;
      out_last_r  <= (CW'(row_r + CW'(1)) == no_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

FILE: verif/discrete_state_space_system_core_tb.sv
`timescale 1ns / 1ps

module discrete_state_space_system_core_tb;
  import dss_pkg::*;

  localparam int MAX_ST         = DEF_MAX_STATES;
  localparam int MAX_IN         = DEF_MAX_INPUTS;
  localparam int OUT_CAP        = (DEF_MAX_OUTPUTS < RESULT_LIMIT) ? DEF_MAX_OUTPUTS
                                                                   : RESULT_LIMIT;
  localparam int COEF_N         = DEF_COEF_DEPTH;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 400;
  localparam int LONG_HOLD      = 600;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 16;
  localparam int HOLD_PHASE     = 1;

  typedef struct {
    op_t                op;
    logic [7:0]         idx;
    logic signed [31:0] val;
    logic               lst;
  } cmd_t;

  typedef struct {
    logic [2:0]         idx;
    logic signed [31:0] val;
    logic               lst;
  } y_elem_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  cfg_reg_t           cfg_index = REG_NUM_STATES;
  logic [CFG_W-1:0]   cfg_value = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  op_t                in_opcode = OP_NONE;
  logic [7:0]         in_index = '0;
  logic signed [31:0] in_value = '0;
  logic               in_last_element = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_index;
  logic signed [31:0] out_value;
  logic               out_last;

  // predictor image of the block
  logic [3:0]         ns_reg = 4'd0;
  logic [3:0]         ni_reg = 4'd1;
  logic [3:0]         no_reg = 4'd1;
  logic signed [31:0] coef_img [COEF_N];
  logic signed [31:0] x_img [MAX_ST];
  logic signed [31:0] u_img [MAX_IN];

  // stimulus bookkeeping
  bit      coef_known [COEF_N];
  bit      in_known [MAX_IN];
  cmd_t    cmd_queue [$];
  y_elem_t y_due [$];
  cmd_t    next_cmd;
  y_elem_t y_head;
  int      phase_items = 0;
  int      errors = 0;
  int      src_idle = 0;
  int      snk_idle = 0;
  int      hold_asks = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;
  bit      calm = 1'b0;

  discrete_state_space_system_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_value       (cfg_value),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_index       (out_index),
    .out_value       (out_value),
    .out_last        (out_last)
  );

  always #4 clk = ~clk;

  function automatic void eff_dims(output int ns, output int ni, output int no);
    ns = (ns_reg > MAX_ST) ? MAX_ST : ns_reg;
    ni = (ni_reg == 0) ? 1 : ((ni_reg > MAX_IN) ? MAX_IN : ni_reg);
    no = (no_reg == 0) ? 1 : ((no_reg > OUT_CAP) ? OUT_CAP : no_reg);
  endfunction

  function automatic logic signed [31:0] coef_at(int addr);
    return (addr >= COEF_N) ? 32'sd0 : coef_img[addr];
  endfunction

  // exact product, then floor to Q16.16
  function automatic logic signed [63:0] qmul_floor(logic signed [31:0] a,
                                                    logic signed [31:0] b);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    wa = a;
    wb = b;
    return (wa * wb) >>> FRAC_W;
  endfunction

  function automatic logic signed [31:0] sat_word(logic signed [63:0] s);
    if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -64'sh8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  // apply one accepted item; a closing sample queues y and advances x
  task automatic ss_absorb(op_t op, logic [7:0] idx, logic signed [31:0] val, logic lst);
    int ns, ni, no, lb, lc, ld, i, j;
    logic signed [63:0] acc;
    logic signed [31:0] x_old [MAX_ST];
    y_elem_t y;
    case (op)
      OP_COEF: if (idx < COEF_N) coef_img[idx] = val;
      OP_STATE: if (idx < MAX_ST) x_img[idx] = val;
      OP_SAMPLE: begin
        if (idx < MAX_IN) u_img[idx] = val;
        if (lst) begin
          eff_dims(ns, ni, no);
          lb = ns * ns;
          lc = lb + ns * ni;
          ld = lc + ns * no;
          for (i = 0; i < no; i++) begin
            acc = '0;
            for (j = 0; j < ns; j++) acc += qmul_floor(coef_at(lc + j * no + i), x_img[j]);
            for (j = 0; j < ni; j++) acc += qmul_floor(coef_at(ld + j * no + i), u_img[j]);
            y.idx = 3'(i);
            y.val = sat_word(acc);
            y.lst = (i == no - 1);
            y_due.push_back(y);
          end
          x_old = x_img;
          for (i = 0; i < ns; i++) begin
            acc = '0;
            for (j = 0; j < ns; j++) acc += qmul_floor(coef_at(j * ns + i), x_old[j]);
            for (j = 0; j < ni; j++) acc += qmul_floor(coef_at(lb + j * ns + i), u_img[j]);
            x_img[i] = sat_word(acc);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic void queue_cmd(op_t op, int idx, logic signed [31:0] v, logic l);
    cmd_t c;
    c.op = op;
    c.idx = 8'(idx);
    c.val = v;
    c.lst = l;
    cmd_queue.push_back(c);
    if (op == OP_COEF && idx < COEF_N) coef_known[idx] = 1'b1;
    if (op == OP_SAMPLE && idx < MAX_IN) in_known[idx] = 1'b1;
    if (op != OP_NONE) phase_items++;
  endfunction

  // mostly within +-0.25, sometimes extremes or full range
  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom();
      3: return 32'sh0001_0000;
      4: return -32'sh0001_0000;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_data();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $urandom();
      default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  // one well-formed vector with random content, plus some noise around it
  task automatic send_vector();
    int ns, ni, no, need, j;
    eff_dims(ns, ni, no);
    need = ns * ns + ns * ni + ns * no + no * ni;
    for (j = 0; j < need; j++)
      if (!coef_known[j]) queue_cmd(OP_COEF, j, rand_coef(), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3))
      queue_cmd(OP_COEF, $urandom_range(0, COEF_N - 1), rand_coef(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        queue_cmd(OP_STATE, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, MAX_ST - 1),
                  rand_data(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 5) == 0)
      queue_cmd(OP_NONE, $urandom_range(0, 255), $urandom(), 1'($urandom_range(0, 1)));
    // broken fragment: samples without a closing mark
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3))
        queue_cmd(OP_SAMPLE, $urandom_range(0, 255), rand_data(), 1'b0);
    for (j = 0; j < ni - 1; j++)
      if (!in_known[j] || $urandom_range(0, 3) != 0)
        queue_cmd(OP_SAMPLE, j, rand_data(), 1'b0);
    if ($urandom_range(0, 4) != 0) begin
      queue_cmd(OP_SAMPLE, ni - 1, rand_data(), 1'b1);
    end else begin
      // close on an element outside the vector
      queue_cmd(OP_SAMPLE, ni - 1, rand_data(), 1'b0);
      queue_cmd(OP_SAMPLE, $urandom_range(ni, 255), rand_data(), 1'b1);
    end
  endtask

  task automatic cfg_write(cfg_reg_t r, logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_value <= v;
    case (r)
      REG_NUM_STATES: ns_reg = v;
      REG_NUM_INPUTS: ni_reg = v;
      REG_NUM_OUTPUTS: no_reg = v;
      default: ;
    endcase
  endtask

  // wait for the block to go quiet
  task automatic settle();
    while (cmd_queue.size() != 0 || in_valid || y_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= OP_NONE;
      in_index <= '0;
      in_value <= '0;
      in_last_element <= 1'b0;
    end else begin
      if (in_valid && !in_stall) ss_absorb(in_opcode, in_index, in_value, in_last_element);
      if (!in_valid || !in_stall) begin
        if (src_idle > 0) begin
          src_idle = src_idle - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_idle = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          next_cmd = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_cmd.op;
          in_index <= next_cmd.idx;
          in_value <= next_cmd.val;
          in_last_element <= next_cmd.lst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (y_due.size() == 0) begin
          $display("%0t unexpected result: index %0d value %h last %b",
                   $time, out_index, out_value, out_last);
          errors++;
        end else begin
          y_head = y_due.pop_front();
          if (out_index !== y_head.idx) begin
            $display("%0t out_index: expected %0d got %0d", $time, y_head.idx, out_index);
            errors++;
          end
          if (out_value !== y_head.val) begin
            $display("%0t out_value: expected %h got %h", $time, y_head.val, out_value);
            errors++;
          end
          if (out_last !== y_head.lst) begin
            $display("%0t out_last: expected %b got %b", $time, y_head.lst, out_last);
            errors++;
          end
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (snk_idle > 0) begin
        snk_idle = snk_idle - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        snk_idle = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles", $time, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    logic [3:0] ns_v, ni_v, no_v;
    foreach (coef_img[k]) coef_img[k] = '0;
    foreach (x_img[k]) x_img[k] = '0;
    foreach (u_img[k]) u_img[k] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // feedthrough only after reset: y = D u with a single tap at address 0
    queue_cmd(OP_COEF, 0, 32'sh0001_0000, 1'b0);
    queue_cmd(OP_SAMPLE, 0, 32'sh7FFF_FFFF, 1'b1);
    queue_cmd(OP_SAMPLE, 0, 32'sh8000_0000, 1'b1);
    queue_cmd(OP_COEF, 0, 32'sh7FFF_FFFF, 1'b1);
    queue_cmd(OP_SAMPLE, 0, 32'sh7FFF_FFFF, 1'b1);
    queue_cmd(OP_SAMPLE, 0, 32'sh8000_0000, 1'b1);
    queue_cmd(OP_COEF, 0, 32'sh8000_0000, 1'b0);
    queue_cmd(OP_SAMPLE, 0, 32'sh8000_0000, 1'b1);
    // smallest products round toward minus infinity
    queue_cmd(OP_COEF, 0, 32'sh0000_0001, 1'b0);
    queue_cmd(OP_SAMPLE, 0, -32'sh1, 1'b1);
    queue_cmd(OP_SAMPLE, 0, 32'sh0000_FFFF, 1'b1);
    queue_cmd(OP_NONE, 255, $urandom(), 1'b1);
    queue_cmd(OP_STATE, 0, 32'sh0003_0000, 1'b1);
    queue_cmd(OP_STATE, 255, -32'sh1, 1'b0);
    queue_cmd(OP_COEF, 255, 32'sh0002_0000, 1'b0);
    queue_cmd(OP_SAMPLE, 7, 32'sh0000_1234, 1'b0);
    queue_cmd(OP_SAMPLE, 200, 32'sh0000_0005, 1'b1);
    queue_cmd(OP_SAMPLE, 0, 32'sh0000_0000, 1'b0);
    queue_cmd(OP_SAMPLE, 1, 32'sh7FFF_FFFF, 1'b1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin ns_v = 4'd1; ni_v = 4'd1; no_v = 4'd1; end
        1: begin ns_v = 4'd2; ni_v = 4'd3; no_v = 4'd2; end
        2: begin ns_v = 4'd8; ni_v = 4'd8; no_v = 4'd8; end
        3: begin ns_v = 4'd0; ni_v = 4'd8; no_v = 4'd8; end
        4: begin ns_v = 4'd15; ni_v = 4'd0; no_v = 4'd15; end
        5: begin ns_v = 4'd8; ni_v = 4'd1; no_v = 4'd1; end
        default: begin
          ns_v = 4'($urandom_range(0, 15));
          ni_v = 4'($urandom_range(0, 15));
          no_v = 4'($urandom_range(0, 15));
        end
      endcase
      cfg_write(REG_NUM_STATES, ns_v);
      cfg_write(REG_NUM_INPUTS, ni_v);
      cfg_write(REG_NUM_OUTPUTS, no_v);
      if (ph == 0) cfg_write(REG_UNUSED, 4'($urandom_range(0, 15)));
      @(posedge clk);
      cfg_we <= 1'b0;
      // back up the result side while items keep coming
      if (ph == HOLD_PHASE) hold_asks++;
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      phase_items = 0;
      send_vector();
      send_vector();
      while (phase_items < PHASE_ITEMS) send_vector();
    end

    settle();
    if (errors == 0 && y_due.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
design/dss_pkg.sv
design/dss_mac.sv
design/discrete_state_space_system_core.sv
verif/discrete_state_space_system_core_tb.sv
